// ===== hdl/ita_pkg.sv =====
// Shared types and constants for the integer-to-ASCII formatter.
// Used by ita_ctrl, ita_dpath and the top level; no dependencies.
`default_nettype none

package ita_pkg;

	localparam logic [2:0] KIND_SDEC = 3'd0;
	localparam logic [2:0] KIND_UDEC = 3'd1;
	localparam logic [2:0] KIND_LHEX = 3'd2;
	localparam logic [2:0] KIND_UHEX = 3'd3;
	localparam logic [2:0] KIND_OCT  = 3'd4;

	localparam logic [7:0] ASC_SPACE = 8'h20;
	localparam logic [7:0] ASC_MINUS = 8'h2D;
	localparam logic [7:0] ASC_ZERO  = 8'h30;
	localparam logic [7:0] ASC_LX    = 8'h78;
	localparam logic [7:0] ASC_UX    = 8'h58;
	localparam logic [7:0] ASC_LA    = 8'h61;
	localparam logic [7:0] ASC_UA    = 8'h41;

	typedef enum logic [2:0] {
		CH_SPACE,
		CH_MINUS,
		CH_ZERO,
		CH_X,
		CH_DIGIT
	} char_sel_t;

	typedef struct packed {
		logic      load;
		logic      dabble;
		logic      extract;
		logic      size;
		logic      pad_dec;
		logic      dig_pop;
		logic      emit;
		char_sel_t sel;
		logic      last;
	} ctl_cmd_t;

	typedef struct packed {
		logic dec;
		logic last_bit;
		logic ex_last;
		logic pad0;
		logic pad_zero;
		logic pad_one;
		logic neg;
		logic prefix;
		logic dig_one;
	} ctl_sts_t;

	function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
		logic [7:0] r;
		if (d < 4'd10)
			r = ASC_ZERO + {4'd0, d};
		else if (upper)
			r = ASC_UA + {4'd0, d - 4'd10};
		else
			r = ASC_LA + {4'd0, d - 4'd10};
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ita_ctrl.sv =====
// Sequencing state machine of the formatter: conversion, digit split, sizing, emission.
// Depends on ita_pkg for the command and status structs.
`default_nettype none

module ita_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  ita_pkg::ctl_sts_t  sts,
	output ita_pkg::ctl_cmd_t  cmd
);
	import ita_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CONV,
		S_EXTRACT,
		S_SIZE,
		S_PAD_SP,
		S_SIGN,
		S_PRE0,
		S_PREX,
		S_PAD_Z,
		S_DIGITS
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.sel   = CH_SPACE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_CONV;
				end
			end
			S_CONV: begin
				if (!sts.dec) begin
					state_nxt = S_EXTRACT;
				end else begin
					cmd.dabble = 1'b1;
					if (sts.last_bit)
						state_nxt = S_EXTRACT;
				end
			end
			S_EXTRACT: begin
				cmd.extract = 1'b1;
				if (sts.ex_last)
					state_nxt = S_SIZE;
			end
			S_SIZE: begin
				cmd.size  = 1'b1;
				state_nxt = S_PAD_SP;
			end
			S_PAD_SP: begin
				if (sts.pad0 || sts.pad_zero) begin
					state_nxt = S_SIGN;
				end else begin
					cmd.emit    = 1'b1;
					cmd.sel     = CH_SPACE;
					cmd.pad_dec = 1'b1;
					if (sts.pad_one)
						state_nxt = S_SIGN;
				end
			end
			S_SIGN: begin
				if (sts.neg) begin
					cmd.emit = 1'b1;
					cmd.sel  = CH_MINUS;
				end
				state_nxt = S_PRE0;
			end
			S_PRE0: begin
				if (sts.prefix) begin
					cmd.emit  = 1'b1;
					cmd.sel   = CH_ZERO;
					state_nxt = S_PREX;
				end else begin
					state_nxt = S_PAD_Z;
				end
			end
			S_PREX: begin
				cmd.emit  = 1'b1;
				cmd.sel   = CH_X;
				state_nxt = S_PAD_Z;
			end
			S_PAD_Z: begin
				if (!sts.pad0 || sts.pad_zero) begin
					state_nxt = S_DIGITS;
				end else begin
					cmd.emit    = 1'b1;
					cmd.sel     = CH_ZERO;
					cmd.pad_dec = 1'b1;
					if (sts.pad_one)
						state_nxt = S_DIGITS;
				end
			end
			S_DIGITS: begin
				cmd.emit    = 1'b1;
				cmd.sel     = CH_DIGIT;
				cmd.dig_pop = 1'b1;
				if (sts.dig_one) begin
					cmd.last  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	ast_dabble_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dabble |-> sts.dec)
		else $error("dabble step on a non-decimal word");

	ast_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |=> !busy)
		else $error("final character did not return to idle");

	ast_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy && !cmd.emit)
		else $error("load not followed by conversion");

endmodule

`default_nettype wire

// ===== hdl/ita_dpath.sv =====
// Datapath of the formatter: magnitude, binary-to-BCD shifter, digit buffer,
// pad counter and registered character output. Depends on ita_pkg.
`default_nettype none

module ita_dpath #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_WIDTH  = 63
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire  [2:0]         cmd_kind,
	input  wire  [31:0]        value,
	input  wire  [5:0]         min_width,
	input  wire                zero_pad,
	input  wire                hex_prefix,
	input  ita_pkg::ctl_cmd_t  cmd,
	output ita_pkg::ctl_sts_t  sts,
	output logic               strobe,
	output logic [7:0]         char_code,
	output logic               last
);
	import ita_pkg::*;

	localparam int VB   = VALUE_BITS;
	localparam int NDIG = VB * 3 / 10 + 1;
	localparam int WW   = NDIG * 4;
	localparam int NBUF = (VB + 2) / 3;
	localparam int IW   = $clog2(NBUF);
	localparam int NW   = $clog2(NBUF + 1);
	localparam int CW   = $clog2(VB);
	localparam logic [5:0] MAXW = 6'(MAX_WIDTH);

	logic [VB-1:0] vin;
	logic          in_neg;
	logic [VB-1:0] in_mag;
	logic          in_dec;
	logic          in_hex;

	logic          dec_q;
	logic          oct_q;
	logic          upper_q;
	logic          neg_q;
	logic          prefix_q;
	logic          pad0_q;
	logic [5:0]    width_q;
	logic [VB-1:0] mag_q;
	logic [WW-1:0] work_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [5:0]    pad_q;
	logic [3:0]    buf_q [NBUF];

	logic [WW-1:0] adj;
	logic [WW-1:0] shifted;
	logic [3:0]    ex_dig;
	logic [5:0]    body;
	logic [IW-1:0] rd_idx;
	logic [3:0]    rd_dig;
	logic [7:0]    ch;

	logic          strobe_q;
	logic [7:0]    char_q;
	logic          last_q;

	assign vin    = VB'(value);
	assign in_neg = (cmd_kind == KIND_SDEC) && vin[VB-1];
	assign in_mag = in_neg ? (~vin + VB'(1)) : vin;
	assign in_hex = (cmd_kind == KIND_LHEX) || (cmd_kind == KIND_UHEX);
	assign in_dec = !in_hex && (cmd_kind != KIND_OCT);

	always_comb begin
		adj = work_q;
		for (int i = 0; i < NDIG; i++) begin
			if (work_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = work_q[4*i +: 4] + 4'd3;
		end
	end

	assign shifted = oct_q ? (work_q >> 3) : (work_q >> 4);
	assign ex_dig  = oct_q ? {1'b0, work_q[2:0]} : work_q[3:0];
	assign body    = 6'(n_q) + {5'd0, neg_q} + (prefix_q ? 6'd2 : 6'd0);
	assign rd_idx  = IW'(n_q - NW'(1));
	assign rd_dig  = buf_q[rd_idx];

	always_comb begin
		case (cmd.sel)
			CH_SPACE: ch = ASC_SPACE;
			CH_MINUS: ch = ASC_MINUS;
			CH_ZERO:  ch = ASC_ZERO;
			CH_X:     ch = upper_q ? ASC_UX : ASC_LX;
			CH_DIGIT: ch = digit_ascii(rd_dig, upper_q);
			default:  ch = ASC_SPACE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= ch;
			last_q <= cmd.last;
		end
		if (cmd.load) begin
			dec_q    <= in_dec;
			oct_q    <= (cmd_kind == KIND_OCT);
			upper_q  <= (cmd_kind == KIND_UHEX);
			neg_q    <= in_neg;
			prefix_q <= in_hex && hex_prefix;
			pad0_q   <= zero_pad;
			width_q  <= (min_width > MAXW) ? MAXW : min_width;
			mag_q    <= in_mag;
			work_q   <= in_dec ? '0 : WW'(in_mag);
			cnt_q    <= '0;
			n_q      <= '0;
		end
		if (cmd.dabble) begin
			work_q <= {adj[WW-2:0], mag_q[VB-1]};
			mag_q  <= mag_q << 1;
			cnt_q  <= cnt_q + CW'(1);
		end
		if (cmd.extract) begin
			buf_q[n_q[IW-1:0]] <= ex_dig;
			n_q                <= n_q + NW'(1);
			work_q             <= shifted;
		end
		if (cmd.size)
			pad_q <= (width_q > body) ? (width_q - body) : 6'd0;
		if (cmd.pad_dec)
			pad_q <= pad_q - 6'd1;
		if (cmd.dig_pop)
			n_q <= n_q - NW'(1);
	end

	assign sts.dec      = dec_q;
	assign sts.last_bit = (cnt_q == CW'(VB - 1));
	assign sts.ex_last  = (shifted == '0);
	assign sts.pad0     = pad0_q;
	assign sts.pad_zero = (pad_q == 6'd0);
	assign sts.pad_one  = (pad_q == 6'd1);
	assign sts.neg      = neg_q;
	assign sts.prefix   = prefix_q;
	assign sts.dig_one  = (n_q == NW'(1));

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

	ast_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |=> !strobe_q)
		else $error("character emitted right after a final character");

	ast_pad_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pad_dec |-> pad_q != 6'd0)
		else $error("pad count underflow");

	ast_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dig_pop |-> n_q != '0)
		else $error("digit read from empty buffer");

	ast_buf_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.extract |-> n_q < NW'(NBUF))
		else $error("digit buffer overflow");

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_formatter_unit.sv =====
// Integer-to-ASCII formatter: one value in, its printf-style text out, one character a word.
// On start the value is loaded; decimal kinds run shift-add-3 steps over every value bit,
// then the digits are split into a buffer, the pad is sized, and space fill, sign, 0x/0X
// prefix, zero fill and digits follow, with strobe low in steps that emit nothing.
// The receiver cannot stall; next word accepted once busy is low.
// arst_n clears the sequencer and the output strobe; other registers are not reset.
`default_nettype none

module integer_to_ascii_formatter_unit #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_WIDTH  = 63
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  cmd,
	input  wire  [31:0] value,
	input  wire  [5:0]  min_width,
	input  wire         zero_pad,
	input  wire         hex_prefix,
	output logic        strobe,
	output logic [7:0]  char_code,
	output logic        last
);
	import ita_pkg::*;

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;

	ita_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (ctl_sts),
		.cmd    (ctl_cmd)
	);

	ita_dpath #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_kind   (cmd),
		.value      (value),
		.min_width  (min_width),
		.zero_pad   (zero_pad),
		.hex_prefix (hex_prefix),
		.cmd        (ctl_cmd),
		.sts        (ctl_sts),
		.strobe     (strobe),
		.char_code  (char_code),
		.last       (last)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for integer_to_ascii_formatter_unit: directed table, then random words.
// Predicts each character from the inputs and checks strobed output in order.
// Depends on ita_pkg and the RTL top level only.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ita_pkg::*;

	localparam logic [2:0] KIND_UNK5 = 3'd5;
	localparam logic [2:0] KIND_UNK6 = 3'd6;
	localparam logic [2:0] KIND_UNK7 = 3'd7;
	localparam int RANDOM_WORDS = 206;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DIR_ROWS     = 24;

	typedef struct {
		logic [7:0] code;
		logic       fin;
	} char_t;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] val;
		logic [5:0]  width;
		logic        zp;
		logic        hp;
		string       text;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [31:0] value;
	logic [5:0]  min_width;
	logic        zero_pad;
	logic        hex_prefix;
	logic        strobe;
	logic [7:0]  char_code;
	logic        last;

	char_t pending_chars[$];
	char_t want;
	int    errors = 0;
	int    cycles = 0;
	int    burst_left = 0;

	// empty text: expectation comes from render_number
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{KIND_SDEC, 32'h0000_0000, 6'd0,  1'b0, 1'b0, "0"},
		'{KIND_SDEC, 32'h7FFF_FFFF, 6'd0,  1'b0, 1'b0, "2147483647"},
		'{KIND_SDEC, 32'h8000_0000, 6'd0,  1'b0, 1'b0, "-2147483648"},
		'{KIND_SDEC, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0, "-1"},
		'{KIND_UDEC, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0, "4294967295"},
		'{KIND_LHEX, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1, "0xffffffff"},
		'{KIND_UHEX, 32'hDEAD_BEEF, 6'd0,  1'b0, 1'b1, "0XDEADBEEF"},
		'{KIND_OCT,  32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0, "37777777777"},
		'{KIND_LHEX, 32'h0000_0000, 6'd0,  1'b0, 1'b1, "0x0"},
		'{KIND_OCT,  32'h0000_0008, 6'd0,  1'b0, 1'b1, "10"},
		'{KIND_UDEC, 32'd123,       6'd0,  1'b0, 1'b1, "123"},
		'{KIND_SDEC, 32'd77,        6'd0,  1'b1, 1'b1, "77"},
		'{KIND_UNK5, 32'd42,        6'd0,  1'b0, 1'b0, "42"},
		'{KIND_UNK6, 32'd0,         6'd0,  1'b0, 1'b0, "0"},
		'{KIND_UNK7, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1, "4294967295"},
		'{KIND_SDEC, 32'hFFFF_FFD6, 6'd6,  1'b1, 1'b0, "-00042"},
		'{KIND_SDEC, 32'hFFFF_FFD6, 6'd6,  1'b0, 1'b0, "   -42"},
		'{KIND_LHEX, 32'h0000_00AB, 6'd8,  1'b1, 1'b1, "0x0000ab"},
		'{KIND_UHEX, 32'h0000_00AB, 6'd8,  1'b0, 1'b1, "    0XAB"},
		'{KIND_UDEC, 32'd12345,     6'd3,  1'b0, 1'b0, "12345"},
		'{KIND_UDEC, 32'd7,         6'd63, 1'b0, 1'b0, ""},
		'{KIND_SDEC, 32'h8000_0000, 6'd63, 1'b1, 1'b0, ""},
		'{KIND_UHEX, 32'h0000_0000, 6'd63, 1'b1, 1'b1, ""},
		'{KIND_OCT,  32'h1234_5678, 6'd63, 1'b0, 1'b0, ""}
	};

	integer_to_ascii_formatter_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.value      (value),
		.min_width  (min_width),
		.zero_pad   (zero_pad),
		.hex_prefix (hex_prefix),
		.strobe     (strobe),
		.char_code  (char_code),
		.last       (last)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void render_number(input logic [2:0] k, input logic [31:0] v,
		input logic [5:0] w, input logic zp, input logic hp);
		logic [31:0] mag;
		logic [31:0] radix;
		logic [31:0] d;
		logic        neg;
		logic        pre;
		logic        up;
		logic [7:0]  digs[$];
		logic [7:0]  line[$];
		int          pad;
		mag = v;
		radix = 32'd10;
		neg = 1'b0;
		pre = 1'b0;
		up = 1'b0;
		case (k)
			KIND_SDEC: begin
				if (v[31]) begin
					neg = 1'b1;
					mag = 32'd0 - v;
				end
			end
			KIND_LHEX, KIND_UHEX: begin
				radix = 32'd16;
				up = (k == KIND_UHEX);
				pre = hp;
			end
			KIND_OCT: radix = 32'd8;
			default: ;
		endcase
		do begin
			d = mag % radix;
			if (d < 32'd10)
				digs.push_front(ASC_ZERO + 8'(d));
			else
				digs.push_front((up ? ASC_UA : ASC_LA) + 8'(d - 32'd10));
			mag = mag / radix;
		end while (mag != 32'd0);
		pad = int'(w) - digs.size() - (neg ? 1 : 0) - (pre ? 2 : 0);
		if (!zp)
			for (int i = 0; i < pad; i++)
				line.push_back(ASC_SPACE);
		if (neg)
			line.push_back(ASC_MINUS);
		if (pre) begin
			line.push_back(ASC_ZERO);
			line.push_back(up ? ASC_UX : ASC_LX);
		end
		if (zp)
			for (int i = 0; i < pad; i++)
				line.push_back(ASC_ZERO);
		line = {line, digs};
		foreach (line[i])
			pending_chars.push_back('{line[i], i == line.size() - 1});
	endfunction

	// bursts of back-to-back words, separated by gaps of random length
	task automatic send_word(input logic [2:0] k, input logic [31:0] v, input logic [5:0] w,
		input logic zp, input logic hp, input string text);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 130) : $urandom_range(1, 6);
			repeat (gap) @(negedge clk) start <= 1'b0;
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= k;
		value <= v;
		min_width <= w;
		zero_pad <= zp;
		hex_prefix <= hp;
		do
			@(posedge clk);
		while (busy);
		if (text.len() > 0) begin
			for (int i = 0; i < text.len(); i++)
				pending_chars.push_back('{8'(text[i]), i == text.len() - 1});
		end else begin
			render_number(k, v, w, zp, hp);
		end
		burst_left--;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected char_code %h last %b", $time, char_code, last);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				if (char_code !== want.code) begin
					$display("%0t: char_code expected %h got %h", $time, want.code, char_code);
					errors++;
				end
				if (last !== want.fin) begin
					$display("%0t: last expected %b got %b", $time, want.fin, last);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [2:0]  k;
		logic [31:0] v;
		logic [5:0]  w;
		int          r;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = KIND_SDEC;
		value = 32'd0;
		min_width = 6'd0;
		zero_pad = 1'b0;
		hex_prefix = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_word(dir_tab[i].kind, dir_tab[i].val, dir_tab[i].width,
				dir_tab[i].zp, dir_tab[i].hp, dir_tab[i].text);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			k = 3'($urandom_range(0, 7));
			if (k > KIND_OCT && $urandom_range(0, 2) != 0)
				k = 3'($urandom_range(0, 4));
			case ($urandom_range(0, 5))
				0: v = 32'($urandom_range(0, 20));
				1: v = 32'h8000_0000 ^ 32'($urandom_range(0, 3));
				2: v = $urandom >> $urandom_range(0, 31);
				3: v = ~32'($urandom_range(0, 300));
				default: v = $urandom;
			endcase
			r = $urandom_range(0, 9);
			if (r < 7)
				w = 6'($urandom_range(0, 12));
			else if (r < 9)
				w = 6'($urandom_range(13, 40));
			else
				w = 6'($urandom_range(41, 63));
			send_word(k, v, w, 1'($urandom), 1'($urandom), "");
		end
		@(negedge clk) start <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/ita_pkg.sv
hdl/ita_ctrl.sv
hdl/ita_dpath.sv
hdl/integer_to_ascii_formatter_unit.sv
tb/sv/tb.sv
